// ===== hw/rtl/fmcb_pkg.sv =====
package fmcb_pkg;

    localparam int CHAN_W        = 8;
    localparam int NUM_LANES     = 4;
    localparam int COLOR_W       = CHAN_W * NUM_LANES;
    localparam int ADDR_W        = 24;
    localparam int XY_W          = 13;
    localparam int POS_W         = XY_W - 1;
    localparam int DIM_CFG_W     = 13;
    localparam int SCIS_POS_W    = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;
    localparam int PROD_W        = 2 * CHAN_W;
    localparam int ALPHA_LANE    = 3;
    localparam int MAX_FRAME_DIM_DEF = 4096;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    typedef enum logic [1:0] {
        DROP_NONE    = 2'd0,
        DROP_ALPHA   = 2'd1,
        DROP_FRAME   = 2'd2,
        DROP_SCISSOR = 2'd3
    } drop_reason_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 3'd0,
        CFG_FRAME_HEIGHT   = 3'd1,
        CFG_SCISSOR_ENABLE = 3'd2,
        CFG_SCISSOR_LEFT   = 3'd3,
        CFG_SCISSOR_TOP    = 3'd4,
        CFG_SCISSOR_WIDTH  = 3'd5,
        CFG_SCISSOR_HEIGHT = 3'd6,
        CFG_TEXTURE_ENABLE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_CFG_W-1:0]  frame_width;
        logic [DIM_CFG_W-1:0]  frame_height;
        logic                  scissor_enable;
        logic [SCIS_POS_W-1:0] scissor_left;
        logic [SCIS_POS_W-1:0] scissor_top;
        logic [DIM_CFG_W-1:0]  scissor_width;
        logic [DIM_CFG_W-1:0]  scissor_height;
    } clip_cfg_t;

    typedef struct packed {
        logic out_frame;
        logic out_scissor;
    } clip_flags_t;

    // Exact floor(p / 255) for p up to 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + (PROD_W+1)'(1) + (PROD_W+1)'(p[PROD_W-1:CHAN_W]);
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

// ===== hw/rtl/fragment_modulate_clip_blend.sv =====
// Fragment back end: texture modulate, frame and scissor clip, source-over blend.
//
// Input channel (s_*): one fragment per word - position, vertex color, texel
// and the framebuffer word currently at that pixel. Result channel (m_*): one
// word per fragment, either a framebuffer write (write enable, address, color)
// or a drop with its reason (alpha zero, outside frame, outside scissor).
// Configuration port (cfg_*): single-cycle register writes, no read-back;
// write only while no fragment is in flight.
//
// Throughput: one fragment per clock unless the receiver stalls the output. The
// four register stages, the first loaded at the accepting edge, are the
// modulate multiply, the source select, the blend multiplies and the output
// register.
// Four channel lanes run side by side; the output stage merges their results
// with the clip flags and the row-times-stride address.
//
// Reset (aresetn low, synchronous): empty the pipeline and load the default
// configuration (640 x 480 frame, scissor and texturing off).
// Receiver stall: when the output word is held and m_ready is low, the whole
// pipeline freezes and s_ready drops in the same cycle.
module fragment_modulate_clip_blend #(
    parameter int MAX_FRAME_DIM = fmcb_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic [fmcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fmcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // fragment in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fmcb_pkg::XY_W-1:0]       s_frag_x,
    input  logic [fmcb_pkg::XY_W-1:0]       s_frag_y,
    input  logic [fmcb_pkg::COLOR_W-1:0]    s_vertex_color,
    input  logic [fmcb_pkg::COLOR_W-1:0]    s_texel_color,
    input  logic [fmcb_pkg::COLOR_W-1:0]    s_dest_color,
    // result out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_write_enable,
    output logic [fmcb_pkg::ADDR_W-1:0]     m_pixel_address,
    output logic [fmcb_pkg::COLOR_W-1:0]    m_pixel_color,
    output logic [1:0]                      m_drop_reason
);
    import fmcb_pkg::*;

    clip_cfg_t          clip_cfg_reg;
    logic               texture_enable_reg;

    logic               advance;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               out_valid_reg;

    logic [CHAN_W-1:0]  lane_src   [NUM_LANES];
    logic [CHAN_W-1:0]  lane_blend [NUM_LANES];
    logic [CHAN_W-1:0]  alpha2;
    logic               alpha_zero3_reg;
    logic [COLOR_W-1:0] blend_color;

    clip_flags_t        clip_flags;
    logic [ADDR_W-1:0]  clip_addr;

    drop_reason_t       reason_next;
    drop_reason_t       reason_reg;
    logic               we_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] color_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_cfg_reg.frame_width    <= DIM_CFG_W'(640);
            clip_cfg_reg.frame_height   <= DIM_CFG_W'(480);
            clip_cfg_reg.scissor_enable <= 1'b0;
            clip_cfg_reg.scissor_left   <= '0;
            clip_cfg_reg.scissor_top    <= '0;
            clip_cfg_reg.scissor_width  <= '0;
            clip_cfg_reg.scissor_height <= '0;
            texture_enable_reg          <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:    clip_cfg_reg.frame_width    <= cfg_wdata;
                CFG_FRAME_HEIGHT:   clip_cfg_reg.frame_height   <= cfg_wdata;
                CFG_SCISSOR_ENABLE: clip_cfg_reg.scissor_enable <= cfg_wdata[0];
                CFG_SCISSOR_LEFT:   clip_cfg_reg.scissor_left   <= cfg_wdata[SCIS_POS_W-1:0];
                CFG_SCISSOR_TOP:    clip_cfg_reg.scissor_top    <= cfg_wdata[SCIS_POS_W-1:0];
                CFG_SCISSOR_WIDTH:  clip_cfg_reg.scissor_width  <= cfg_wdata;
                CFG_SCISSOR_HEIGHT: clip_cfg_reg.scissor_height <= cfg_wdata;
                CFG_TEXTURE_ENABLE: texture_enable_reg          <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance every stage unless the output word is held by the receiver.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= s_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // One lane per color channel; the alpha lane feeds its source alpha
    // to every lane for the blend multiplies.
    assign alpha2 = lane_src[ALPHA_LANE];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        fmcb_lane u_lane (
            .aclk       (aclk),
            .en         (advance),
            .tex_en     (texture_enable_reg),
            .vert_chan  (s_vertex_color[k*CHAN_W +: CHAN_W]),
            .texel_chan (s_texel_color[k*CHAN_W +: CHAN_W]),
            .dest_chan  (s_dest_color[k*CHAN_W +: CHAN_W]),
            .alpha_i    (alpha2),
            .src_o      (lane_src[k]),
            .blend_o    (lane_blend[k])
        );
        assign blend_color[k*CHAN_W +: CHAN_W] = lane_blend[k];
    end

    fmcb_clip #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_clip (
        .aclk    (aclk),
        .en      (advance),
        .cfg     (clip_cfg_reg),
        .frag_x  (s_frag_x),
        .frag_y  (s_frag_y),
        .flags_o (clip_flags),
        .addr_o  (clip_addr)
    );

    // Hold the alpha-zero flag alongside stage 3.
    always_ff @(posedge aclk) begin
        if (advance) begin
            alpha_zero3_reg <= (alpha2 == '0);
        end
    end

    // Merge: first cause wins - alpha, then frame, then scissor.
    always_comb begin
        if (alpha_zero3_reg) begin
            reason_next = DROP_ALPHA;
        end else if (clip_flags.out_frame) begin
            reason_next = DROP_FRAME;
        end else if (clip_flags.out_scissor) begin
            reason_next = DROP_SCISSOR;
        end else begin
            reason_next = DROP_NONE;
        end
    end

    // Output register; drop words carry zero address and color.
    always_ff @(posedge aclk) begin
        if (advance) begin
            reason_reg <= reason_next;
            we_reg     <= (reason_next == DROP_NONE);
            addr_reg   <= (reason_next == DROP_NONE) ? clip_addr : '0;
            color_reg  <= (reason_next == DROP_NONE) ? blend_color : '0;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_write_enable  = we_reg;
    assign m_pixel_address = addr_reg;
    assign m_pixel_color   = color_reg;
    assign m_drop_reason   = reason_reg;

endmodule

// ===== hw/rtl/fmcb_lane.sv =====
module fmcb_lane (
    input  logic                       aclk,
    input  logic                       en,
    input  logic                       tex_en,
    input  logic [fmcb_pkg::CHAN_W-1:0] vert_chan,
    input  logic [fmcb_pkg::CHAN_W-1:0] texel_chan,
    input  logic [fmcb_pkg::CHAN_W-1:0] dest_chan,
    input  logic [fmcb_pkg::CHAN_W-1:0] alpha_i,
    output logic [fmcb_pkg::CHAN_W-1:0] src_o,
    output logic [fmcb_pkg::CHAN_W-1:0] blend_o
);
    import fmcb_pkg::*;

    logic [PROD_W-1:0] mod_prod_reg;
    logic [CHAN_W-1:0] vert1_reg;
    logic [CHAN_W-1:0] dest1_reg;
    logic [CHAN_W-1:0] src2_reg;
    logic [CHAN_W-1:0] dest2_reg;
    logic [PROD_W-1:0] src_part_reg;
    logic [PROD_W-1:0] dest_part_reg;
    logic [PROD_W:0]   blend_sum;

    // Stage 1: texel times vertex channel.
    // Stage 2: pick modulated or plain vertex channel.
    // Stage 3: both blend products.
    always_ff @(posedge aclk) begin
        if (en) begin
            mod_prod_reg  <= texel_chan * vert_chan;
            vert1_reg     <= vert_chan;
            dest1_reg     <= dest_chan;
            src2_reg      <= tex_en ? div255(mod_prod_reg) : vert1_reg;
            dest2_reg     <= dest1_reg;
            src_part_reg  <= src2_reg * alpha_i;
            dest_part_reg <= dest2_reg * (CHAN_MAX - alpha_i);
        end
    end

    assign src_o     = src2_reg;
    assign blend_sum = {1'b0, src_part_reg} + {1'b0, dest_part_reg};
    // Sum never exceeds 255 * 255, so the top bit is always clear.
    assign blend_o   = div255(blend_sum[PROD_W-1:0]);

endmodule

// ===== hw/rtl/fmcb_clip.sv =====
module fmcb_clip #(
    parameter int MAX_FRAME_DIM = fmcb_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                        aclk,
    input  logic                        en,
    input  fmcb_pkg::clip_cfg_t         cfg,
    input  logic [fmcb_pkg::XY_W-1:0]   frag_x,
    input  logic [fmcb_pkg::XY_W-1:0]   frag_y,
    output fmcb_pkg::clip_flags_t       flags_o,
    output logic [fmcb_pkg::ADDR_W-1:0] addr_o
);
    import fmcb_pkg::*;

    localparam int DIM_W  = $clog2(MAX_FRAME_DIM + 1);
    localparam int CW     = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam int MUL_W  = POS_W + CW;
    localparam int SEND_W = SCIS_POS_W + 2;

    logic [CW-1:0]     fw_ext;
    logic [CW-1:0]     fh_ext;
    logic [CW-1:0]     w_sat;
    logic [CW-1:0]     h_sat;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic [SEND_W-1:0] sc_right;
    logic [SEND_W-1:0] sc_bottom;
    logic              out_frame;
    logic              out_box;

    clip_flags_t       flags1_reg;
    clip_flags_t       flags2_reg;
    clip_flags_t       flags3_reg;
    logic [POS_W-1:0]  x1_reg;
    logic [POS_W-1:0]  y1_reg;
    logic [POS_W-1:0]  x2_reg;
    logic [MUL_W-1:0]  row_base_reg;
    logic [ADDR_W-1:0] addr3_reg;
    logic [MUL_W-1:0]  addr_sum;

    // Saturate the frame size; the stride uses the same saturated width.
    assign fw_ext = CW'(cfg.frame_width);
    assign fh_ext = CW'(cfg.frame_height);
    assign w_sat  = (fw_ext > CW'(MAX_FRAME_DIM)) ? CW'(MAX_FRAME_DIM) : fw_ext;
    assign h_sat  = (fh_ext > CW'(MAX_FRAME_DIM)) ? CW'(MAX_FRAME_DIM) : fh_ext;

    assign x_pos = frag_x[POS_W-1:0];
    assign y_pos = frag_y[POS_W-1:0];

    assign out_frame = frag_x[XY_W-1] || frag_y[XY_W-1] ||
                       (CW'(x_pos) >= w_sat) || (CW'(y_pos) >= h_sat);

    // Only consulted when the frame test passed, so x and y are not negative.
    assign sc_right  = SEND_W'(cfg.scissor_left) + SEND_W'(cfg.scissor_width);
    assign sc_bottom = SEND_W'(cfg.scissor_top) + SEND_W'(cfg.scissor_height);
    assign out_box   = (x_pos < cfg.scissor_left) || (SEND_W'(x_pos) >= sc_right) ||
                       (y_pos < cfg.scissor_top)  || (SEND_W'(y_pos) >= sc_bottom);

    assign addr_sum = row_base_reg + MUL_W'(x2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            flags1_reg.out_frame   <= out_frame;
            flags1_reg.out_scissor <= cfg.scissor_enable && out_box;
            x1_reg                 <= x_pos;
            y1_reg                 <= y_pos;
            flags2_reg             <= flags1_reg;
            x2_reg                 <= x1_reg;
            row_base_reg           <= y1_reg * w_sat;
            flags3_reg             <= flags2_reg;
            addr3_reg              <= addr_sum[ADDR_W-1:0];
        end
    end

    assign flags_o = flags3_reg;
    assign addr_o  = addr3_reg;

endmodule

// ===== hw/rtl/fmcb_checker.sv =====
module fmcb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_write_enable,
    input logic [fmcb_pkg::ADDR_W-1:0]     m_pixel_address,
    input logic [fmcb_pkg::COLOR_W-1:0]    m_pixel_color,
    input logic [1:0]                      m_drop_reason
);
    import fmcb_pkg::*;

    // Output word held while stalled.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_pixel_color) && $stable(m_pixel_address) &&
                                $stable(m_drop_reason) && $stable(m_write_enable))
        else $error("result word changed while stalled");

    // Input side backs up only behind a held output word.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without an output stall");

    // Write words carry no reason; drop words carry nothing else.
    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_enable == (m_drop_reason == DROP_NONE)) &&
                    (m_write_enable || (m_pixel_color == '0 && m_pixel_address == '0)))
        else $error("write enable, reason and payload disagree");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind fragment_modulate_clip_blend fmcb_checker u_fmcb_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_write_enable  (m_write_enable),
    .m_pixel_address (m_pixel_address),
    .m_pixel_color   (m_pixel_color),
    .m_drop_reason   (m_drop_reason)
);
